/* hdl/swbd_pkg.sv */
// Shared types and constants for the short-window back-reference decoder.
package swbd_pkg;

   localparam logic [7:0] ESC_TOKEN   = 8'hFF;
   localparam int         HIST_AW     = 5;
   localparam int         FILL_W      = HIST_AW + 1;
   localparam logic [FILL_W-1:0] WINDOW = FILL_W'(32);
   localparam int         QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_REF = 2'd1,
      ST_ESC_END = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_LIT  = 2'd0,
      CMD_COPY = 2'd1,
      CMD_ERR  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [7:0]          value;
      logic [HIST_AW-1:0]  src;
      logic [HIST_AW-1:0]  dst;
      logic [2:0]          len_m1;
      status_type          status;
      logic                chunk_last;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_READ = 2'd1,
      BK_COPY = 2'd2
   } back_state_type;

endpackage

/* hdl/swbd_front.sv */
// Front end: accepts token bytes, tracks chunk state, issues decode commands.
module swbd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_token_byte,
   input  logic              req_chunk_end,
   input  logic              q_full,
   output logic              q_push,
   output swbd_pkg::cmd_type q_cmd
);

   logic [swbd_pkg::HIST_AW-1:0] wp_ff, wp_in;
   logic [swbd_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic                         esc_ff, esc_in;
   logic                         err_ff, err_in;

   logic                         accept;
   logic [3:0]                   cnt;
   logic [swbd_pkg::FILL_W-1:0]  ref_dist;
   logic [swbd_pkg::FILL_W:0]    fill_sum;
   logic [swbd_pkg::FILL_W-1:0]  fill_add;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign cnt       = {1'b0, req_token_byte[2:0]} + 4'd1;
   assign ref_dist  = swbd_pkg::WINDOW - {1'b0, req_token_byte[7:3]};

   always_comb begin
      fill_sum = '0;
      fill_add = '0;
      wp_in    = wp_ff;
      fill_in  = fill_ff;
      esc_in   = esc_ff;
      err_in   = err_ff;
      q_push   = 1'b0;
      q_cmd.kind       = swbd_pkg::CMD_LIT;
      q_cmd.value      = req_token_byte;
      q_cmd.src        = wp_ff + req_token_byte[7:3];
      q_cmd.dst        = wp_ff;
      q_cmd.len_m1     = req_token_byte[2:0];
      q_cmd.status     = swbd_pkg::ST_OK;
      q_cmd.chunk_last = req_chunk_end;
      if (accept) begin
         if (err_ff) begin
            q_push = 1'b0;
         end else if (esc_ff) begin
            esc_in   = 1'b0;
            q_push   = 1'b1;
            fill_add = swbd_pkg::FILL_W'(1);
            wp_in    = wp_ff + 1'b1;
         end else if (req_token_byte == swbd_pkg::ESC_TOKEN) begin
            if (req_chunk_end) begin
               err_in       = 1'b1;
               q_push       = 1'b1;
               q_cmd.kind   = swbd_pkg::CMD_ERR;
               q_cmd.status = swbd_pkg::ST_ESC_END;
            end else begin
               esc_in = 1'b1;
            end
         end else if (ref_dist > fill_ff || swbd_pkg::FILL_W'(cnt) > ref_dist) begin
            err_in       = 1'b1;
            q_push       = 1'b1;
            q_cmd.kind   = swbd_pkg::CMD_ERR;
            q_cmd.status = swbd_pkg::ST_BAD_REF;
         end else begin
            q_push     = 1'b1;
            q_cmd.kind = swbd_pkg::CMD_COPY;
            fill_add   = swbd_pkg::FILL_W'(cnt);
            wp_in      = wp_ff + swbd_pkg::HIST_AW'(cnt);
         end
         fill_sum = {1'b0, fill_ff} + {1'b0, fill_add};
         if (fill_sum > {1'b0, swbd_pkg::WINDOW}) begin
            fill_in = swbd_pkg::WINDOW;
         end else begin
            fill_in = fill_sum[swbd_pkg::FILL_W-1:0];
         end
         if (req_chunk_end) begin
            wp_in   = '0;
            fill_in = '0;
            esc_in  = 1'b0;
            err_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
         esc_ff  <= 1'b0;
         err_ff  <= 1'b0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
         esc_ff  <= esc_in;
         err_ff  <= err_in;
      end
   end

endmodule

/* hdl/swbd_queue.sv */
// Small command queue between front and back ends.
module swbd_queue #(
   parameter int DEPTH = swbd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  swbd_pkg::cmd_type push_cmd,
   input  logic              pop,
   output swbd_pkg::cmd_type pop_cmd,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   swbd_pkg::cmd_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/swbd_back.sv */
// Back end: history memory, copy sequencer and output register.
module swbd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  swbd_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_data_byte,
   output logic [1:0]        rsp_status,
   output logic              rsp_last_of_run,
   output logic              rsp_chunk_last
);

   swbd_pkg::back_state_type     state_ff, state_in;
   logic [7:0]                   history_ff [1 << swbd_pkg::HIST_AW];
   logic [7:0]                   rd_data_ff;
   logic [swbd_pkg::HIST_AW-1:0] src_ff, src_in;
   logic [swbd_pkg::HIST_AW-1:0] dst_ff, dst_in;
   logic [2:0]                   left_ff, left_in;
   logic                         chunk_ff, chunk_in;

   logic                         out_valid_ff, out_valid_in;
   logic [7:0]                   out_data_ff, out_data_in;
   swbd_pkg::status_type         out_status_ff, out_status_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_chunk_ff, out_chunk_in;

   logic                         advance, load_out;
   logic                         wr_en, rd_en;
   logic [swbd_pkg::HIST_AW-1:0] wr_addr, rd_addr;
   logic [7:0]                   wr_data;

   assign advance = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      left_in       = left_ff;
      chunk_in      = chunk_ff;
      q_pop         = 1'b0;
      load_out      = 1'b0;
      out_data_in   = out_data_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      out_chunk_in  = out_chunk_ff;
      wr_en         = 1'b0;
      wr_addr       = dst_ff;
      wr_data       = rd_data_ff;
      rd_en         = 1'b0;
      rd_addr       = src_ff;
      unique case (state_ff)
         swbd_pkg::BK_IDLE: begin
            if (!q_empty) begin
               unique case (q_cmd.kind)
                  swbd_pkg::CMD_COPY: begin
                     q_pop    = 1'b1;
                     src_in   = q_cmd.src;
                     dst_in   = q_cmd.dst;
                     left_in  = q_cmd.len_m1;
                     chunk_in = q_cmd.chunk_last;
                     state_in = swbd_pkg::BK_READ;
                  end
                  swbd_pkg::CMD_LIT: begin
                     if (advance) begin
                        q_pop         = 1'b1;
                        load_out      = 1'b1;
                        out_data_in   = q_cmd.value;
                        out_status_in = swbd_pkg::ST_OK;
                        out_last_in   = 1'b1;
                        out_chunk_in  = q_cmd.chunk_last;
                        wr_en         = 1'b1;
                        wr_addr       = q_cmd.dst;
                        wr_data       = q_cmd.value;
                     end
                  end
                  swbd_pkg::CMD_ERR: begin
                     if (advance) begin
                        q_pop         = 1'b1;
                        load_out      = 1'b1;
                        out_data_in   = '0;
                        out_status_in = q_cmd.status;
                        out_last_in   = 1'b1;
                        out_chunk_in  = q_cmd.chunk_last;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         swbd_pkg::BK_READ: begin
            rd_en    = 1'b1;
            src_in   = src_ff + 1'b1;
            state_in = swbd_pkg::BK_COPY;
         end
         swbd_pkg::BK_COPY: begin
            if (advance) begin
               load_out      = 1'b1;
               out_data_in   = rd_data_ff;
               out_status_in = swbd_pkg::ST_OK;
               out_last_in   = (left_ff == '0);
               out_chunk_in  = chunk_ff;
               wr_en         = 1'b1;
               dst_in        = dst_ff + 1'b1;
               if (left_ff == '0) begin
                  state_in = swbd_pkg::BK_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  src_in  = src_ff + 1'b1;
                  left_in = left_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = swbd_pkg::BK_IDLE;
         end
      endcase
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         history_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= history_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      left_ff       <= left_in;
      chunk_ff      <= chunk_in;
      out_data_ff   <= out_data_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
      out_chunk_ff  <= out_chunk_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swbd_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_data_byte   = out_data_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_chunk_last  = out_chunk_ff;

endmodule

/* hdl/short_window_backref_decoder.sv */
// Top level of the short-window back-reference decoder.
//
//   channel   dir   handshake          payload
//   req_      in    valid / stall      token_byte[7:0], chunk_end
//   rsp_      out   valid / stall      data_byte[7:0], status[1:0], last_of_run, chunk_last
//
// The front end takes one request per cycle while the command queue has room;
// escapes and swallowed bytes cost it nothing more.
// The back end loads a literal or error result as it pops it, and runs a copy
// with one history read to prime, then one byte per cycle while the response is not stalled.
// Synchronous reset clears control state; the history memory is not cleared.
// A stalled response holds the back end's output; the queue keeps the front running until it fills.
module short_window_backref_decoder #(
   parameter int QUEUE_DEPTH = swbd_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_token_byte,
   input  logic       req_chunk_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last_of_run,
   output logic       rsp_chunk_last
);

   logic              q_push, q_pop, q_full, q_empty;
   swbd_pkg::cmd_type push_cmd, pop_cmd;

   swbd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_token_byte (req_token_byte),
      .req_chunk_end  (req_chunk_end),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (push_cmd)
   );

   swbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   swbd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_cmd           (pop_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_chunk_last  (rsp_chunk_last)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command queue overflow");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command queue underflow");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != swbd_pkg::ST_OK) |->
         (rsp_last_of_run && rsp_data_byte == 8'd0))
      else $error("error result must be a single zero byte");

endmodule
